/* hdl/lmx_pkg.sv */
// Shared constants, codes and types of the Lamport mutual exclusion node.
`default_nettype none

package lmx_pkg;

  // Fixed field widths of the ports.
  localparam int SITE_W       = 3;
  localparam int MSG_TIME_W   = 32;
  localparam int MODE_W       = 3;
  localparam int KIND_W       = 2;
  localparam int SITE_COUNT_W = 4;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 4;

  // Defaults of the top-level parameters.
  localparam int MAX_SITES_DEF   = 8;
  localparam int CLOCK_WIDTH_DEF = 32;

  // Reset values of the configuration registers.
  localparam logic [SITE_W-1:0]       OWN_SITE_RST   = 3'd0;
  localparam logic [SITE_COUNT_W-1:0] SITE_COUNT_RST = 4'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_OWN_SITE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SITE_COUNT = 2'd1;

  // Event codes of an input beat.
  localparam logic [MODE_W-1:0] MODE_RECV_REQ = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RECV_GNT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RECV_REL = 3'd2;
  localparam logic [MODE_W-1:0] MODE_LOCAL    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OWN_REQ  = 3'd4;

  // Message kinds of an output beat.
  localparam logic [KIND_W-1:0] KIND_GRANT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REQUEST = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ENTERED = 2'd3;

  // Queue operations.
  localparam logic [1:0] Q_NOP         = 2'd0;
  localparam logic [1:0] Q_INSERT      = 2'd1;
  localparam logic [1:0] Q_REMOVE_SITE = 2'd2;
  localparam logic [1:0] Q_REMOVE_HEAD = 2'd3;

  // Command to the queue row; the key time travels beside it.
  typedef struct packed {
    logic [1:0]        op;
    logic [SITE_W-1:0] site;
  } q_cmd_t;

  // Tag of one queue entry.
  typedef struct packed {
    logic              valid;
    logic [SITE_W-1:0] site;
  } q_tag_t;

  // Status of the queue row seen by the sequencer.
  typedef struct packed {
    logic              empty;
    logic              full;
    logic [SITE_W-1:0] head_site;
  } q_stat_t;

endpackage

`default_nettype wire

/* hdl/lmx_cell.sv */
// One cell of the sorted request queue: holds one entry and trades with its neighbors.
`default_nettype none

module lmx_cell #(
  parameter int TW = lmx_pkg::CLOCK_WIDTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  lmx_pkg::q_cmd_t      cmd,
  input  wire  [TW-1:0]        key_time,
  input  lmx_pkg::q_tag_t      left_tag,
  input  wire  [TW-1:0]        left_time,
  input  wire                  left_flag,
  input  lmx_pkg::q_tag_t      right_tag,
  input  wire  [TW-1:0]        right_time,
  output lmx_pkg::q_tag_t      cell_tag,
  output logic [TW-1:0]        cell_time,
  output logic                 flag_out
);

  logic                       cell_valid;
  logic [lmx_pkg::SITE_W-1:0] cell_site;
  lmx_pkg::q_tag_t            tag_next;
  logic [TW-1:0]              time_next;
  logic                       key_lt;
  logic                       hit;
  logic                       found;

  assign cell_tag.valid = cell_valid;
  assign cell_tag.site  = cell_site;

  // An empty cell counts as larger than any key; ties order by site.
  assign key_lt = !cell_valid || (key_time < cell_time) ||
                  ((key_time == cell_time) && (cmd.site < cell_site));

  // Removal marks the first matching entry; cells from there on pull from the right.
  assign hit   = cell_valid && ((cmd.op == lmx_pkg::Q_REMOVE_HEAD) || (cell_site == cmd.site));
  assign found = left_flag || hit;

  // Next entry of this cell.
  always_comb begin
    tag_next  = cell_tag;
    time_next = cell_time;
    flag_out  = 1'b0;
    unique case (cmd.op) inside
      lmx_pkg::Q_INSERT: begin
        flag_out = key_lt;
        if (key_lt && left_flag) begin
          tag_next  = left_tag;
          time_next = left_time;
        end else if (key_lt) begin
          tag_next.valid = 1'b1;
          tag_next.site  = cmd.site;
          time_next      = key_time;
        end
      end
      lmx_pkg::Q_REMOVE_SITE, lmx_pkg::Q_REMOVE_HEAD: begin
        flag_out = found;
        if (found) begin
          tag_next  = right_tag;
          time_next = right_time;
        end
      end
      default: begin
        flag_out = 1'b0;
      end
    endcase
  end

  // Valid bit is control state; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else begin
      cell_valid <= tag_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    cell_site <= tag_next.site;
    cell_time <= time_next;
  end

endmodule

`default_nettype wire

/* hdl/lmx_queue.sv */
// Row of queue cells holding the pending requests sorted by time and site.
`default_nettype none

module lmx_queue #(
  parameter int MAX_SITES = lmx_pkg::MAX_SITES_DEF,
  parameter int TW        = lmx_pkg::CLOCK_WIDTH_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  lmx_pkg::q_cmd_t  cmd,
  input  wire  [TW-1:0]    key_time,
  output lmx_pkg::q_stat_t stat
);

  lmx_pkg::q_tag_t cell_tags  [MAX_SITES];
  logic [TW-1:0]   cell_times [MAX_SITES];
  logic            cell_flags [MAX_SITES];
  lmx_pkg::q_cmd_t cmd_eff;
  logic            full;

  assign full = cell_tags[MAX_SITES-1].valid;

  // An insert into a full row is dropped so that no entry falls off the end.
  always_comb begin
    cmd_eff = cmd;
    if ((cmd.op == lmx_pkg::Q_INSERT) && full) begin
      cmd_eff.op = lmx_pkg::Q_NOP;
    end
  end

  // Cell chain: each cell sees its left and right neighbor.
  for (genvar i = 0; i < MAX_SITES; i++) begin : g_cell
    lmx_pkg::q_tag_t left_tag;
    logic [TW-1:0]   left_time;
    logic            left_flag;
    lmx_pkg::q_tag_t right_tag;
    logic [TW-1:0]   right_time;

    if (i == 0) begin : g_first
      assign left_tag  = '0;
      assign left_time = '0;
      assign left_flag = 1'b0;
    end else begin : g_inner_left
      assign left_tag  = cell_tags[i-1];
      assign left_time = cell_times[i-1];
      assign left_flag = cell_flags[i-1];
    end

    if (i == MAX_SITES - 1) begin : g_last
      assign right_tag  = '0;
      assign right_time = '0;
    end else begin : g_inner_right
      assign right_tag  = cell_tags[i+1];
      assign right_time = cell_times[i+1];
    end

    lmx_cell #(
      .TW(TW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd_eff),
      .key_time  (key_time),
      .left_tag  (left_tag),
      .left_time (left_time),
      .left_flag (left_flag),
      .right_tag (right_tag),
      .right_time(right_time),
      .cell_tag  (cell_tags[i]),
      .cell_time (cell_times[i]),
      .flag_out  (cell_flags[i])
    );
  end

  assign stat.empty     = !cell_tags[0].valid;
  assign stat.full      = full;
  assign stat.head_site = cell_tags[0].site;

endmodule

`default_nettype wire

/* hdl/lamport_mutex_node.sv */
// Top level of one Lamport mutual exclusion site: clock, grants, sequencer and queue.
// An accepted item is handled in steps: apply the event, check for entry, then load its results
// into the output register one sequencer slot at a time, stalling while the receiver holds off.
// A new item is taken only once the sequencer is back in idle after its last result is loaded.
// Reset: clock, grants, requesting and queue valid bits clear at once; own_site 0, site_count 2.
`default_nettype none

module lamport_mutex_node #(
  parameter int MAX_SITES   = lmx_pkg::MAX_SITES_DEF,
  parameter int CLOCK_WIDTH = lmx_pkg::CLOCK_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // Configuration writes
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [lmx_pkg::CFG_ADDR_W-1:0]    cfg_index,
  input  wire  [lmx_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Input events
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire  [lmx_pkg::MODE_W-1:0]        mode,
  input  wire  [lmx_pkg::MSG_TIME_W-1:0]    msg_time,
  input  wire  [lmx_pkg::SITE_W-1:0]        msg_site,
  // Output messages
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [lmx_pkg::KIND_W-1:0]        out_kind,
  output logic [lmx_pkg::SITE_W-1:0]        dest_site,
  output logic [lmx_pkg::MSG_TIME_W-1:0]    stamp_time,
  output logic                              last
);

  localparam int CW    = CLOCK_WIDTH;
  localparam int CNT_W = $clog2(MAX_SITES + 1);
  localparam int TOT_W = CNT_W + 1;
  localparam int IW    = (CNT_W > lmx_pkg::SITE_W) ? CNT_W : lmx_pkg::SITE_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVENT = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [1:0] PH_GRANT   = 2'd0;
  localparam logic [1:0] PH_REQ     = 2'd1;
  localparam logic [1:0] PH_NOTICE  = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  // Configuration registers
  logic [lmx_pkg::SITE_W-1:0]       own_site;
  logic [lmx_pkg::SITE_COUNT_W-1:0] site_count;

  // Site state
  logic [CW-1:0]        logical_clock;
  logic                 requesting;
  logic [MAX_SITES-1:0] grant_bits;

  // Held input beat
  logic [lmx_pkg::MODE_W-1:0] cur_mode;
  logic [CW-1:0]              cur_time;
  logic [lmx_pkg::SITE_W-1:0] cur_site;

  // Sequencer
  logic [1:0]       state;
  logic [1:0]       phase;
  logic [CNT_W-1:0] ev_count;
  logic [CNT_W-1:0] emit_total;
  logic [CNT_W-1:0] emit_cnt;
  logic [CNT_W-1:0] idx;
  logic [CW-1:0]    ev_stamp;
  logic [CW-1:0]    en_stamp;

  // Combinational helpers
  logic [CNT_W-1:0]     cnt;
  logic [MAX_SITES-1:0] need;
  logic [MAX_SITES-1:0] grant_hit;
  logic [MAX_SITES-1:0] own_onehot;
  logic [CW-1:0]        merged;
  logic [CW-1:0]        clock_inc;
  logic                 own_lt_cnt;
  logic                 own_req_ok;
  logic                 entry_ok;
  logic [CNT_W-1:0]     rel_count;
  logic [TOT_W-1:0]     total;
  logic                 in_fire;
  logic                 load_ok;
  logic                 idx_is_own;
  logic                 idx_last;
  logic                 cand_valid;
  logic [lmx_pkg::KIND_W-1:0] cand_kind;
  logic [lmx_pkg::SITE_W-1:0] cand_dest;
  logic [CW-1:0]              cand_stamp;
  logic                 cand_last;

  lmx_pkg::q_cmd_t  q_cmd;
  logic [CW-1:0]    q_key_time;
  lmx_pkg::q_stat_t q_stat;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_ok   = !out_valid || out_ready;

  // Effective site count: zero counts as one, the row depth caps it.
  always_comb begin
    if (site_count == '0) begin
      cnt = CNT_W'(1);
    end else if (int'(site_count) > MAX_SITES) begin
      cnt = CNT_W'(MAX_SITES);
    end else begin
      cnt = CNT_W'(site_count);
    end
  end

  // Per-site masks.
  always_comb begin
    for (int i = 0; i < MAX_SITES; i++) begin
      need[i]       = (i < int'(cnt));
      grant_hit[i]  = (i == int'(cur_site));
      own_onehot[i] = (i == int'(own_site));
    end
  end

  assign merged     = ((cur_time > logical_clock) ? cur_time : logical_clock);
  assign clock_inc  = logical_clock + CW'(1);
  assign own_lt_cnt = IW'(own_site) < IW'(cnt);
  assign own_req_ok = !requesting && own_lt_cnt && !q_stat.full;
  assign entry_ok   = requesting && !q_stat.empty && (q_stat.head_site == own_site) &&
                      ((grant_bits & need) == need);
  assign rel_count  = cnt - (own_lt_cnt ? CNT_W'(1) : CNT_W'(0));
  assign total      = TOT_W'(ev_count) +
                      (entry_ok ? (TOT_W'(rel_count) + TOT_W'(1)) : TOT_W'(0));

  // Queue command: event updates in the event state, head removal on entry in the check state.
  always_comb begin
    q_cmd.op   = lmx_pkg::Q_NOP;
    q_cmd.site = cur_site;
    q_key_time = cur_time;
    if (state == ST_EVENT) begin
      unique case (cur_mode) inside
        lmx_pkg::MODE_RECV_REQ: q_cmd.op = lmx_pkg::Q_INSERT;
        lmx_pkg::MODE_RECV_REL: q_cmd.op = lmx_pkg::Q_REMOVE_SITE;
        lmx_pkg::MODE_OWN_REQ: begin
          if (own_req_ok) begin
            q_cmd.op   = lmx_pkg::Q_INSERT;
            q_cmd.site = own_site;
            q_key_time = clock_inc;
          end
        end
        default: q_cmd.op = lmx_pkg::Q_NOP;
      endcase
    end else if ((state == ST_CHECK) && entry_ok) begin
      q_cmd.op = lmx_pkg::Q_REMOVE_HEAD;
    end
  end

  lmx_queue #(
    .MAX_SITES(MAX_SITES),
    .TW       (CW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .cmd     (q_cmd),
    .key_time(q_key_time),
    .stat    (q_stat)
  );

  // Candidate result of the current emission slot.
  assign idx_is_own = IW'(idx) == IW'(own_site);
  assign idx_last   = idx == (cnt - CNT_W'(1));
  assign cand_last  = (emit_cnt + CNT_W'(1)) == emit_total;

  always_comb begin
    cand_valid = 1'b0;
    cand_kind  = lmx_pkg::KIND_GRANT;
    cand_dest  = cur_site;
    cand_stamp = ev_stamp;
    unique case (phase)
      PH_GRANT: begin
        cand_valid = 1'b1;
      end
      PH_REQ: begin
        cand_valid = !idx_is_own;
        cand_kind  = lmx_pkg::KIND_REQUEST;
        cand_dest  = lmx_pkg::SITE_W'(idx);
      end
      PH_NOTICE: begin
        cand_valid = 1'b1;
        cand_kind  = lmx_pkg::KIND_ENTERED;
        cand_dest  = own_site;
        cand_stamp = en_stamp;
      end
      PH_RELEASE: begin
        cand_valid = !idx_is_own;
        cand_kind  = lmx_pkg::KIND_RELEASE;
        cand_dest  = lmx_pkg::SITE_W'(idx);
        cand_stamp = en_stamp;
      end
      default: cand_valid = 1'b0;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_site   <= lmx_pkg::OWN_SITE_RST;
      site_count <= lmx_pkg::SITE_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lmx_pkg::REG_OWN_SITE:   own_site   <= lmx_pkg::SITE_W'(cfg_data);
        lmx_pkg::REG_SITE_COUNT: site_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Held input beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_mode <= mode;
      cur_time <= CW'(msg_time);
      cur_site <= msg_site;
    end
  end

  // Control sequencer and site state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_GRANT;
      logical_clock <= '0;
      requesting    <= 1'b0;
      grant_bits    <= '0;
      ev_count      <= '0;
      emit_total    <= '0;
      emit_cnt      <= '0;
      idx           <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= ST_EVENT;
          end
        end
        ST_EVENT: begin
          unique case (cur_mode) inside
            lmx_pkg::MODE_RECV_REQ: begin
              state         <= ST_CHECK;
              logical_clock <= merged + CW'(2);
              ev_stamp      <= merged + CW'(2);
              ev_count      <= CNT_W'(1);
              phase         <= PH_GRANT;
            end
            lmx_pkg::MODE_RECV_GNT: begin
              state         <= ST_CHECK;
              ev_count      <= '0;
              phase         <= PH_NOTICE;
              logical_clock <= merged + CW'(1);
              grant_bits    <= grant_bits | grant_hit;
            end
            lmx_pkg::MODE_RECV_REL: begin
              state         <= ST_CHECK;
              ev_count      <= '0;
              phase         <= PH_NOTICE;
              logical_clock <= merged + CW'(1);
            end
            lmx_pkg::MODE_LOCAL: begin
              state         <= ST_CHECK;
              ev_count      <= '0;
              phase         <= PH_NOTICE;
              logical_clock <= clock_inc;
            end
            lmx_pkg::MODE_OWN_REQ: begin
              state <= ST_CHECK;
              if (own_req_ok) begin
                logical_clock <= clock_inc;
                ev_stamp      <= clock_inc;
                requesting    <= 1'b1;
                grant_bits    <= own_onehot;
                ev_count      <= cnt - CNT_W'(1);
                phase         <= (cnt != CNT_W'(1)) ? PH_REQ : PH_NOTICE;
              end else begin
                ev_count <= '0;
                phase    <= PH_NOTICE;
              end
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_CHECK: begin
          emit_cnt <= '0;
          idx      <= '0;
          if (total > TOT_W'(MAX_SITES)) begin
            emit_total <= CNT_W'(MAX_SITES);
          end else begin
            emit_total <= CNT_W'(total);
          end
          if (entry_ok) begin
            grant_bits    <= '0;
            logical_clock <= clock_inc;
            en_stamp      <= clock_inc;
            requesting    <= 1'b0;
          end
          state <= (total == '0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          if (load_ok) begin
            if (cand_valid) begin
              emit_cnt <= emit_cnt + CNT_W'(1);
              if (cand_last) begin
                state <= ST_IDLE;
              end
            end
            unique case (phase)
              PH_GRANT:  phase <= PH_NOTICE;
              PH_NOTICE: begin
                phase <= PH_RELEASE;
                idx   <= '0;
              end
              PH_REQ: begin
                if (idx_last) begin
                  phase <= PH_NOTICE;
                  idx   <= '0;
                end else begin
                  idx <= idx + CNT_W'(1);
                end
              end
              PH_RELEASE: begin
                if (!idx_last) begin
                  idx <= idx + CNT_W'(1);
                end
              end
              default: phase <= PH_GRANT;
            endcase
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && load_ok && cand_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && load_ok && cand_valid) begin
      out_kind   <= cand_kind;
      dest_site  <= cand_dest;
      stamp_time <= lmx_pkg::MSG_TIME_W'(cand_stamp);
      last       <= cand_last;
    end
  end

  // The queue row stays packed from the head.
  a_queue_packed: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.empty && q_stat.full))
    else $error("queue holds an entry at the tail while the head is empty");

  // The emission counter never passes the planned result count.
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (emit_cnt < emit_total))
    else $error("emission ran past its planned count");

  // Leaving the emission phase always leaves a final beat in the output register.
  a_last_on_exit: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == ST_EMIT && state == ST_IDLE) |-> (out_valid && last))
    else $error("emission ended without a final beat");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// Self-checking testbench of the Lamport mutual exclusion node, with a built-in site model.
`timescale 1ns / 100ps

module tb_top;
  import lmx_pkg::*;

  localparam int          QDEPTH       = MAX_SITES_DEF;
  localparam int          PHASES       = 8;
  localparam int          PHASE_ITEMS  = 43;
  // Once every result is out, this drain gives the node ample time to return to idle.
  localparam int          DRAIN_CYCLES = 40;
  localparam longint      TIMEOUT_NS   = 64'd10_000_000;
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  // One outgoing message of the node.
  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [SITE_W-1:0]     dest;
    logic [MSG_TIME_W-1:0] stamp;
    logic                  last;
  } msg_t;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    ROW_EVENT_PRED,
    ROW_EVENT_NONE,
    ROW_EVENT_ONE,
    ROW_CONFIG
  } row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [MODE_W-1:0]       md;
    logic [MSG_TIME_W-1:0]   t;
    logic [SITE_W-1:0]       site;
    logic [SITE_W-1:0]       cfg_own;
    logic [SITE_COUNT_W-1:0] cfg_sites;
    msg_t                    typed;
  } row_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_ADDR_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [MODE_W-1:0]       mode;
  logic [MSG_TIME_W-1:0]   msg_time;
  logic [SITE_W-1:0]       msg_site;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [KIND_W-1:0]       out_kind;
  logic [SITE_W-1:0]       dest_site;
  logic [MSG_TIME_W-1:0]   stamp_time;
  logic                    last;

  int unsigned             send_idle_pct = 0;
  int unsigned             recv_stall_pct = 0;
  int                      fail_count = 0;
  msg_t                    pending_msgs[$];
  msg_t                    step_msgs[$];
  msg_t                    head_msg;
  row_t                    directed_rows[$];

  // Mirror of the site: clock, request queue, grants and configuration.
  logic [MSG_TIME_W-1:0]   lc_clock = '0;
  logic                    lc_requesting = 1'b0;
  logic [QDEPTH-1:0]       lc_grants = '0;
  logic [MSG_TIME_W-1:0]   lc_qtime [0:QDEPTH-1];
  logic [SITE_W-1:0]       lc_qsite [0:QDEPTH-1];
  int                      lc_qcount = 0;
  logic [SITE_W-1:0]       lc_own = OWN_SITE_RST;
  logic [SITE_COUNT_W-1:0] lc_sites = SITE_COUNT_RST;

  lamport_mutex_node u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .msg_time(msg_time),
    .msg_site(msg_site),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .dest_site(dest_site),
    .stamp_time(stamp_time),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Number of sites in effect: zero counts as one, the top is the queue depth.
  function automatic int unsigned site_span();
    int unsigned n;
    n = lc_sites;
    if (n < 1) n = 1;
    if (n > QDEPTH) n = QDEPTH;
    return n;
  endfunction

  function automatic msg_t mk_msg(logic [KIND_W-1:0] k, logic [SITE_W-1:0] d,
                                  logic [MSG_TIME_W-1:0] st);
    msg_t m;
    m.kind  = k;
    m.dest  = d;
    m.stamp = st;
    m.last  = 1'b1;
    return m;
  endfunction

  // Sorted insert by time, then by site; a full queue takes nothing.
  task automatic queue_insert(input logic [MSG_TIME_W-1:0] t, input logic [SITE_W-1:0] s);
    int pos;
    if (lc_qcount < QDEPTH) begin
      pos = lc_qcount;
      while (pos > 0 && (t < lc_qtime[pos-1] || (t == lc_qtime[pos-1] && s < lc_qsite[pos-1])))
      begin
        lc_qtime[pos] = lc_qtime[pos-1];
        lc_qsite[pos] = lc_qsite[pos-1];
        pos--;
      end
      lc_qtime[pos] = t;
      lc_qsite[pos] = s;
      lc_qcount++;
    end
  endtask

  task automatic queue_drop(input int idx);
    if (idx < lc_qcount) begin
      for (int i = idx; i + 1 < lc_qcount; i++) begin
        lc_qtime[i] = lc_qtime[i+1];
        lc_qsite[i] = lc_qsite[i+1];
      end
      lc_qcount--;
    end
  endtask

  // Received timestamps pull the clock forward, then it ticks.
  task automatic merge_time(input logic [MSG_TIME_W-1:0] t);
    if (t > lc_clock) lc_clock = t;
    lc_clock++;
  endtask

  task automatic post_msg(input logic [KIND_W-1:0] k, input logic [SITE_W-1:0] d);
    if (step_msgs.size() < QDEPTH) step_msgs.push_back({k, d, lc_clock, 1'b0});
  endtask

  // Advances the mirror by one event and leaves its messages in step_msgs.
  task automatic track_event(input logic [MODE_W-1:0] md, input logic [MSG_TIME_W-1:0] t,
                             input logic [SITE_W-1:0] s);
    int unsigned cnt;
    int          hit;
    logic [8:0]  need;
    msg_t        tail;
    cnt  = site_span();
    need = (9'd1 << cnt) - 9'd1;
    hit  = -1;
    step_msgs.delete();
    case (md)
      MODE_RECV_REQ: begin
        merge_time(t);
        queue_insert(t, s);
        lc_clock++;
        post_msg(KIND_GRANT, s);
      end
      MODE_RECV_GNT: begin
        merge_time(t);
        lc_grants[s] = 1'b1;
      end
      MODE_RECV_REL: begin
        merge_time(t);
        for (int i = 0; i < lc_qcount; i++)
          if (hit < 0 && lc_qsite[i] == s) hit = i;
        if (hit >= 0) queue_drop(hit);
      end
      MODE_LOCAL: begin
        lc_clock++;
      end
      MODE_OWN_REQ: begin
        if (!lc_requesting && lc_own < cnt && lc_qcount < QDEPTH) begin
          lc_clock++;
          lc_requesting = 1'b1;
          queue_insert(lc_clock, lc_own);
          lc_grants = '0;
          lc_grants[lc_own] = 1'b1;
          for (int i = 0; i < cnt; i++)
            if (i != lc_own) post_msg(KIND_REQUEST, SITE_W'(i));
        end
      end
      default: ;
    endcase

    // Entry into the critical section once every grant is held and our request leads.
    if (md <= MODE_OWN_REQ && lc_requesting && lc_qcount > 0 && lc_qsite[0] == lc_own &&
        (lc_grants & need[QDEPTH-1:0]) == need[QDEPTH-1:0]) begin
      lc_grants = '0;
      lc_clock++;
      post_msg(KIND_ENTERED, lc_own);
      for (int i = 0; i < cnt; i++)
        if (i != lc_own) post_msg(KIND_RELEASE, SITE_W'(i));
      queue_drop(0);
      lc_requesting = 1'b0;
    end

    if (step_msgs.size() > 0) begin
      tail = step_msgs.pop_back();
      tail.last = 1'b1;
      step_msgs.push_back(tail);
    end
  endtask

  // Sends one event beat; called and returning at a falling edge, valid left high.
  task automatic send_event(input row_kind_e k, input logic [MODE_W-1:0] md,
                            input logic [MSG_TIME_W-1:0] t, input logic [SITE_W-1:0] s,
                            input msg_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    mode     = md;
    msg_time = t;
    msg_site = s;
    do @(posedge clk); while (!in_ready);
    track_event(md, t, s);
    if (k == ROW_EVENT_PRED) begin
      foreach (step_msgs[i]) pending_msgs.push_back(step_msgs[i]);
    end else if (k == ROW_EVENT_ONE) begin
      pending_msgs.push_back(typed);
    end
    @(negedge clk);
  endtask

  // Lets every expected message out and the node settle before a register write.
  task automatic drain_idle();
    in_valid = 1'b0;
    while (pending_msgs.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes both registers; bit 3 of the own-site beat is don't-care and is randomized.
  task automatic write_config(input logic [SITE_W-1:0] own, input logic [SITE_COUNT_W-1:0] n);
    cfg_valid = 1'b1;
    cfg_index = REG_OWN_SITE;
    cfg_data  = {1'($urandom_range(1)), own};
    do @(posedge clk); while (!cfg_ready);
    lc_own = cfg_data[SITE_W-1:0];
    @(negedge clk);
    cfg_index = REG_SITE_COUNT;
    cfg_data  = n;
    do @(posedge clk); while (!cfg_ready);
    lc_sites = cfg_data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic add_event(input row_kind_e k, input logic [MODE_W-1:0] md,
                           input logic [MSG_TIME_W-1:0] t, input logic [SITE_W-1:0] s,
                           input msg_t m);
    row_t r;
    r       = '0;
    r.kind  = k;
    r.md    = md;
    r.t     = t;
    r.site  = s;
    r.typed = m;
    directed_rows.push_back(r);
  endtask

  task automatic add_config(input logic [SITE_W-1:0] own, input logic [SITE_COUNT_W-1:0] n);
    row_t r;
    r           = '0;
    r.kind      = ROW_CONFIG;
    r.cfg_own   = own;
    r.cfg_sites = n;
    directed_rows.push_back(r);
  endtask

  // Mostly well-formed traffic aimed at the current state, with some noise.
  task automatic random_event();
    int unsigned           cnt;
    int unsigned           roll;
    int                    cand[$];
    logic [SITE_W-1:0]     s;
    logic [MSG_TIME_W-1:0] near;
    cnt  = site_span();
    roll = $urandom_range(99);
    near = lc_clock + MSG_TIME_W'($urandom_range(6)) - 32'd3;
    s    = SITE_W'($urandom_range(cnt - 1));
    if (roll < 6) begin
      send_event(ROW_EVENT_PRED, MODE_W'($urandom_range(MODE_UNUSED_HI)), $urandom,
                 SITE_W'($urandom_range(7)), '0);
    end else if (roll < 30) begin
      if (s == lc_own) s = SITE_W'($urandom_range(7));
      send_event(ROW_EVENT_PRED, MODE_RECV_REQ, near, s, '0);
    end else if (roll < 52) begin
      // Prefer a grant that is still missing for our pending request.
      for (int i = 0; i < cnt; i++)
        if (!lc_grants[i]) cand.push_back(i);
      if (lc_requesting && cand.size() > 0) s = SITE_W'(cand[$urandom_range(cand.size() - 1)]);
      send_event(ROW_EVENT_PRED, MODE_RECV_GNT, near, s, '0);
    end else if (roll < 72) begin
      // Release a request that another site has queued.
      for (int i = 0; i < lc_qcount; i++)
        if (lc_qsite[i] != lc_own) cand.push_back(lc_qsite[i]);
      if (cand.size() > 0) s = SITE_W'(cand[$urandom_range(cand.size() - 1)]);
      send_event(ROW_EVENT_PRED, MODE_RECV_REL, near, s, '0);
    end else if (roll < 80) begin
      send_event(ROW_EVENT_PRED, MODE_LOCAL, $urandom, SITE_W'($urandom_range(7)), '0);
    end else begin
      send_event(ROW_EVENT_PRED, MODE_OWN_REQ, $urandom, SITE_W'($urandom_range(7)), '0);
    end
  endtask

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every output beat is checked against the oldest expected message.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_msgs.size() == 0) begin
        $error("unexpected message: out_kind %0d dest_site %0d stamp_time %0d",
               out_kind, dest_site, stamp_time);
        fail_count++;
      end else begin
        head_msg = pending_msgs.pop_front();
        if (out_kind !== head_msg.kind) begin
          $error("out_kind expected %0d got %0d", head_msg.kind, out_kind);
          fail_count++;
        end
        if (dest_site !== head_msg.dest) begin
          $error("dest_site expected %0d got %0d", head_msg.dest, dest_site);
          fail_count++;
        end
        if (stamp_time !== head_msg.stamp) begin
          $error("stamp_time expected %0d got %0d", head_msg.stamp, stamp_time);
          fail_count++;
        end
        if (last !== head_msg.last) begin
          $error("last expected %0d got %0d", head_msg.last, last);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin
    rst       = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_OWN_SITE;
    cfg_data  = '0;
    in_valid  = 1'b0;
    mode      = MODE_LOCAL;
    msg_time  = '0;
    msg_site  = '0;

    // Straight after reset: own site 0 among 2 sites, clock at zero.
    add_event(ROW_EVENT_NONE, MODE_LOCAL, 32'hFFFF_FFFF, 3'd7, '0);
    add_event(ROW_EVENT_ONE, MODE_RECV_REQ, 32'd0, 3'd1, mk_msg(KIND_GRANT, 3'd1, 32'd3));
    // The largest timestamp wraps the clock back to zero.
    add_event(ROW_EVENT_NONE, MODE_RECV_GNT, 32'hFFFF_FFFF, 3'd1, '0);
    add_event(ROW_EVENT_ONE, MODE_OWN_REQ, 32'h5A5A_A5A5, 3'd6,
              mk_msg(KIND_REQUEST, 3'd1, 32'd1));
    add_event(ROW_EVENT_PRED, MODE_RECV_GNT, 32'd5, 3'd1, '0);
    add_event(ROW_EVENT_PRED, MODE_RECV_REL, 32'd0, 3'd1, '0);
    add_event(ROW_EVENT_NONE, MODE_UNUSED_LO, 32'hFFFF_FFFF, 3'd7, '0);

    // Ties on time: the lower site goes first, whether or not it is our own request.
    add_config(3'd1, 4'd2);
    add_event(ROW_EVENT_PRED, MODE_RECV_REL, 32'd999, 3'd5, '0);
    add_event(ROW_EVENT_PRED, MODE_OWN_REQ, 32'd0, 3'd0, '0);
    add_event(ROW_EVENT_NONE, MODE_OWN_REQ, 32'd0, 3'd0, '0);
    add_event(ROW_EVENT_PRED, MODE_RECV_REQ, 32'd1001, 3'd0, '0);
    add_event(ROW_EVENT_PRED, MODE_RECV_REQ, 32'd1001, 3'd4, '0);
    add_event(ROW_EVENT_PRED, MODE_RECV_GNT, 32'd0, 3'd0, '0);
    add_event(ROW_EVENT_PRED, MODE_RECV_REL, 32'd0, 3'd0, '0);

    // Own site outside the site count cannot request.
    add_config(3'd6, 4'd2);
    add_event(ROW_EVENT_NONE, MODE_OWN_REQ, 32'hFFFF_FFFF, 3'd7, '0);

    // A lone site enters as soon as it asks.
    add_config(3'd0, 4'd1);
    add_event(ROW_EVENT_PRED, MODE_RECV_REL, 32'd0, 3'd4, '0);
    add_event(ROW_EVENT_PRED, MODE_OWN_REQ, 32'd0, 3'd0, '0);

    // Fill the queue, overflow it with one more request, then ask while full.
    add_config(3'd7, 4'd15);
    for (int s = 0; s < QDEPTH; s++)
      add_event(ROW_EVENT_PRED, MODE_RECV_REQ, 32'd2990 + 32'((s % 3) * 5), SITE_W'(s), '0);
    add_event(ROW_EVENT_PRED, MODE_RECV_REQ, 32'd3000, 3'd3, '0);
    add_event(ROW_EVENT_NONE, MODE_OWN_REQ, 32'd0, 3'd0, '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG) begin
        drain_idle();
        write_config(directed_rows[i].cfg_own, directed_rows[i].cfg_sites);
      end else begin
        send_event(directed_rows[i].kind, directed_rows[i].md, directed_rows[i].t,
                   directed_rows[i].site, directed_rows[i].typed);
      end
    end

    // Random phases, each with its own configuration and idling profile.
    for (int p = 0; p < PHASES; p++) begin
      drain_idle();
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      case (p)
        0: write_config(3'd3, 4'd4);
        1: write_config(3'd7, 4'd8);
        2: write_config(3'd0, 4'd0);
        3: write_config(3'd5, 4'd15);
        4: write_config(3'd2, 4'd3);
        5: write_config(3'd6, 4'd3);
        6: write_config(3'd1, 4'd2);
        default: write_config(SITE_W'($urandom_range(7)), SITE_COUNT_W'($urandom_range(15)));
      endcase
      repeat (PHASE_ITEMS) random_event();
    end

    drain_idle();
    if (fail_count == 0 && pending_msgs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
hdl/lmx_pkg.sv
hdl/lmx_cell.sv
hdl/lmx_queue.sv
hdl/lamport_mutex_node.sv
sim/tb_top.sv
